[hdl/gpe_pkg.sv]
// shared types, register codes and helper functions for the gpio edge interrupt port
`default_nettype none

package gpe_pkg;

    localparam int unsigned NUM_PINS   = 16;
    localparam int unsigned DATA_W     = 32;
    localparam int unsigned NUM_GROUPS = 7;

    typedef enum logic [1:0] {
        KIND_READ  = 2'd0,
        KIND_WRITE = 2'd1,
        KIND_TICK  = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        REG_MODE     = 4'd0,
        REG_OTYPE    = 4'd1,
        REG_SPEED    = 4'd2,
        REG_PULL     = 4'd3,
        REG_IDR      = 4'd4,
        REG_ODR      = 4'd5,
        REG_SETRESET = 4'd6,
        REG_AFLOW    = 4'd7,
        REG_AFHIGH   = 4'd8,
        REG_RISE     = 4'd9,
        REG_FALL     = 4'd10,
        REG_MASK     = 4'd11,
        REG_PENDING  = 4'd12,
        REG_SWTRIG   = 4'd13,
        REG_UNUSED14 = 4'd14,
        REG_UNUSED15 = 4'd15
    } reg_index_t;

    localparam logic [1:0] MODE_OUTPUT = 2'b01;
    localparam logic [1:0] MODE_ANALOG = 2'b11;

    typedef struct packed {
        logic [DATA_W-1:0]     read_data;
        logic [NUM_PINS-1:0]   out_levels;
        logic [NUM_PINS-1:0]   out_enable;
        logic [NUM_PINS-1:0]   open_drain;
        logic [NUM_GROUPS-1:0] irq_lines;
    } result_t;

    // one bit per pin whose 2-bit mode field matches code
    function automatic logic [NUM_PINS-1:0] pins_in_mode(
        input logic [DATA_W-1:0] mode,
        input logic [1:0]        code
    );
        logic [NUM_PINS-1:0] r;
        r = '0;
        for (int p = 0; p < NUM_PINS; p++) begin
            r[p] = (mode[2*p +: 2] == code);
        end
        return r;
    endfunction

    // lines 0-4 each, 5-9 and 10-15 ored together
    function automatic logic [NUM_GROUPS-1:0] irq_groups(
        input logic [NUM_PINS-1:0] act
    );
        logic [NUM_GROUPS-1:0] r;
        r[4:0] = act[4:0];
        r[5]   = |act[9:5];
        r[6]   = |act[15:10];
        return r;
    endfunction

endpackage

`default_nettype wire

[hdl/gpio_port_edge_interrupt_core.sv]
// top level: input register, register file and result register
// an accepted item is held in the input register, then its result in the result register
// throughput: one item per cycle while results are taken; a waiting result lets one more in
// the rate is set by the single register-file update between the two stages
// reset: all port registers, pending bits and both stage valid bits clear to zero
`default_nettype none

module gpio_port_edge_interrupt_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    output logic                                    in_ready,
    input  wire logic [1:0]                         kind,
    input  wire logic [3:0]                         reg_index,
    input  wire logic [gpe_pkg::DATA_W-1:0]         write_data,
    input  wire logic [gpe_pkg::NUM_PINS-1:0]       pin_levels,
    output logic                                    out_valid,
    input  wire logic                               out_ready,
    output logic [gpe_pkg::DATA_W-1:0]              read_data,
    output logic [gpe_pkg::NUM_PINS-1:0]            out_levels,
    output logic [gpe_pkg::NUM_PINS-1:0]            out_enable,
    output logic [gpe_pkg::NUM_PINS-1:0]            open_drain,
    output logic [gpe_pkg::NUM_GROUPS-1:0]          irq_lines
);
    import gpe_pkg::*;

    logic                stage_valid_reg;
    logic [1:0]          kind_reg;
    logic [3:0]          index_reg;
    logic [DATA_W-1:0]   data_reg;
    logic [NUM_PINS-1:0] levels_reg;

    logic    out_valid_reg;
    result_t result_reg;
    result_t result;

    logic out_free;
    logic advance;

    assign out_free = !out_valid_reg || out_ready;
    assign advance  = stage_valid_reg && out_free;
    assign in_ready = !stage_valid_reg || out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stage_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            kind_reg   <= kind;
            index_reg  <= reg_index;
            data_reg   <= write_data;
            levels_reg <= pin_levels;
        end
    end

    gpe_regs u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (advance),
        .kind       (kind_reg),
        .reg_index  (index_reg),
        .write_data (data_reg),
        .pin_levels (levels_reg),
        .result     (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= stage_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result;
        end
    end

    assign out_valid  = out_valid_reg;
    assign read_data  = result_reg.read_data;
    assign out_levels = result_reg.out_levels;
    assign out_enable = result_reg.out_enable;
    assign open_drain = result_reg.open_drain;
    assign irq_lines  = result_reg.irq_lines;

    // an empty result register never holds back the input side
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input stalled with empty result register");

    // both stages full and output stalled: no new item may enter
    assert property (@(posedge clk) disable iff (!rst_n)
        (stage_valid_reg && out_valid_reg && !out_ready) |-> !in_ready)
        else $error("item accepted while pipeline is full");

    // a result only appears after an item sat in the input stage
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(stage_valid_reg))
        else $error("result valid without a staged item");

endmodule

`default_nettype wire

[hdl/gpe_regs.sv]
// port register file: bus access, pin sampling, edge detect and result forming
`default_nettype none

module gpe_regs (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         fire,
    input  wire logic [1:0]                   kind,
    input  wire logic [3:0]                   reg_index,
    input  wire logic [gpe_pkg::DATA_W-1:0]   write_data,
    input  wire logic [gpe_pkg::NUM_PINS-1:0] pin_levels,
    output gpe_pkg::result_t                  result
);
    import gpe_pkg::*;

    logic [DATA_W-1:0]   mode_reg,    mode_next;
    logic [NUM_PINS-1:0] otype_reg,   otype_next;
    logic [DATA_W-1:0]   speed_reg,   speed_next;
    logic [DATA_W-1:0]   pull_reg,    pull_next;
    logic [NUM_PINS-1:0] odr_reg,     odr_next;
    logic [NUM_PINS-1:0] idr_reg,     idr_next;
    logic [DATA_W-1:0]   aflow_reg,   aflow_next;
    logic [DATA_W-1:0]   afhigh_reg,  afhigh_next;
    logic [NUM_PINS-1:0] rise_reg,    rise_next;
    logic [NUM_PINS-1:0] fall_reg,    fall_next;
    logic [NUM_PINS-1:0] mask_reg,    mask_next;
    logic [NUM_PINS-1:0] pending_reg, pending_next;

    logic [NUM_PINS-1:0] lo;
    logic [NUM_PINS-1:0] hi;
    logic [NUM_PINS-1:0] now;
    logic [DATA_W-1:0]   rd;

    assign lo  = write_data[NUM_PINS-1:0];
    assign hi  = write_data[DATA_W-1:NUM_PINS];
    // analog pins always latch zero
    assign now = pin_levels & ~pins_in_mode(mode_reg, MODE_ANALOG);

    always_comb
    begin
        mode_next    = mode_reg;
        otype_next   = otype_reg;
        speed_next   = speed_reg;
        pull_next    = pull_reg;
        odr_next     = odr_reg;
        idr_next     = idr_reg;
        aflow_next   = aflow_reg;
        afhigh_next  = afhigh_reg;
        rise_next    = rise_reg;
        fall_next    = fall_reg;
        mask_next    = mask_reg;
        pending_next = pending_reg;
        rd           = '0;
        case (kind_t'(kind))
            KIND_READ:
            begin
                case (reg_index_t'(reg_index))
                    REG_MODE:    rd = mode_reg;
                    REG_OTYPE:   rd = {{(DATA_W-NUM_PINS){1'b0}}, otype_reg};
                    REG_SPEED:   rd = speed_reg;
                    REG_PULL:    rd = pull_reg;
                    REG_IDR:     rd = {{(DATA_W-NUM_PINS){1'b0}}, idr_reg};
                    REG_ODR:     rd = {{(DATA_W-NUM_PINS){1'b0}}, odr_reg};
                    REG_AFLOW:   rd = aflow_reg;
                    REG_AFHIGH:  rd = afhigh_reg;
                    REG_RISE:    rd = {{(DATA_W-NUM_PINS){1'b0}}, rise_reg};
                    REG_FALL:    rd = {{(DATA_W-NUM_PINS){1'b0}}, fall_reg};
                    REG_MASK:    rd = {{(DATA_W-NUM_PINS){1'b0}}, mask_reg};
                    REG_PENDING: rd = {{(DATA_W-NUM_PINS){1'b0}}, pending_reg};
                    default:     rd = '0;
                endcase
            end
            KIND_WRITE:
            begin
                case (reg_index_t'(reg_index))
                    REG_MODE:     mode_next    = write_data;
                    REG_OTYPE:    otype_next   = lo;
                    REG_SPEED:    speed_next   = write_data;
                    REG_PULL:     pull_next    = write_data;
                    REG_ODR:      odr_next     = lo;
                    // set wins over reset
                    REG_SETRESET: odr_next     = (odr_reg & ~hi) | lo;
                    REG_AFLOW:    aflow_next   = write_data;
                    REG_AFHIGH:   afhigh_next  = write_data;
                    REG_RISE:     rise_next    = lo;
                    REG_FALL:     fall_next    = lo;
                    REG_MASK:     mask_next    = lo;
                    REG_PENDING:  pending_next = pending_reg & ~lo;
                    REG_SWTRIG:   pending_next = pending_reg | lo;
                    default:      ;
                endcase
            end
            KIND_TICK:
            begin
                pending_next = pending_reg
                             | (now & ~idr_reg & rise_reg)
                             | (~now & idr_reg & fall_reg);
                idr_next     = now;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= '0;
            otype_reg   <= '0;
            speed_reg   <= '0;
            pull_reg    <= '0;
            odr_reg     <= '0;
            idr_reg     <= '0;
            aflow_reg   <= '0;
            afhigh_reg  <= '0;
            rise_reg    <= '0;
            fall_reg    <= '0;
            mask_reg    <= '0;
            pending_reg <= '0;
        end
        else if (fire)
        begin
            mode_reg    <= mode_next;
            otype_reg   <= otype_next;
            speed_reg   <= speed_next;
            pull_reg    <= pull_next;
            odr_reg     <= odr_next;
            idr_reg     <= idr_next;
            aflow_reg   <= aflow_next;
            afhigh_reg  <= afhigh_next;
            rise_reg    <= rise_next;
            fall_reg    <= fall_next;
            mask_reg    <= mask_next;
            pending_reg <= pending_next;
        end
    end

    // outputs reflect the state after this item
    assign result.read_data  = rd;
    assign result.out_levels = odr_next;
    assign result.out_enable = pins_in_mode(mode_next, MODE_OUTPUT);
    assign result.open_drain = otype_next;
    assign result.irq_lines  = irq_groups(pending_next & mask_next);

endmodule

`default_nettype wire

[sim/testbench.sv]
// self-checking bench for the gpio edge interrupt core: table-driven directed items, then random
module testbench;
    import gpe_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_ITEMS  = 750;
    localparam int PRINT_LIMIT   = 50;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  kind = KIND_READ;
    logic [3:0]  reg_index = REG_MODE;
    logic [31:0] write_data = '0;
    logic [15:0] pin_levels = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] read_data;
    logic [15:0] out_levels;
    logic [15:0] out_enable;
    logic [15:0] open_drain;
    logic [6:0]  irq_lines;

    // typed-in expectation that travels with the item on the bus
    bit      row_fixed = 1'b0;
    result_t row_want = '0;

    typedef struct {
        kind_t       k;
        reg_index_t  idx;
        logic [31:0] d;
        logic [15:0] lv;
        bit          fixed;
        result_t     want;
    } bus_row_t;

    bus_row_t script[$];
    result_t  replies[$];
    int       err_count = 0;
    int       cycles = 0;
    int       rx_wait = 0;
    bit       calm = 1'b0;

    // port state as the bench sees it
    logic [31:0] p_mode = '0, p_speed = '0, p_pull = '0, p_aflow = '0, p_afhigh = '0;
    logic [15:0] p_otype = '0, p_odr = '0, p_idr = '0;
    logic [15:0] p_rise = '0, p_fall = '0, p_mask = '0, p_pend = '0;

    gpio_port_edge_interrupt_core u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .kind       (kind),
        .reg_index  (reg_index),
        .write_data (write_data),
        .pin_levels (pin_levels),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .read_data  (read_data),
        .out_levels (out_levels),
        .out_enable (out_enable),
        .open_drain (open_drain),
        .irq_lines  (irq_lines)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic int pick_wait();
        if (calm)
            return 0;
        return $urandom_range(0, 6);
    endfunction

    function automatic logic [15:0] mode_match(input logic [31:0] mode, input logic [1:0] code);
        logic [15:0] hits;
        hits = '0;
        for (int p = 0; p < 16; p++)
            hits[p] = (mode[2*p +: 2] == code);
        return hits;
    endfunction

    function automatic result_t idle_reply(input logic [15:0] levels);
        result_t r;
        r = '0;
        r.out_levels = levels;
        return r;
    endfunction

    // applies one bus item to the port state and gives the reply it produces
    task automatic port_next(input kind_t k, input reg_index_t idx, input logic [31:0] d,
                             input logic [15:0] lv, output result_t r);
        logic [31:0] rd;
        logic [15:0] now, act;
        rd = '0;
        case (k)
            KIND_READ:
            begin
                case (idx)
                    REG_MODE:    rd = p_mode;
                    REG_OTYPE:   rd = {16'h0, p_otype};
                    REG_SPEED:   rd = p_speed;
                    REG_PULL:    rd = p_pull;
                    REG_IDR:     rd = {16'h0, p_idr};
                    REG_ODR:     rd = {16'h0, p_odr};
                    REG_AFLOW:   rd = p_aflow;
                    REG_AFHIGH:  rd = p_afhigh;
                    REG_RISE:    rd = {16'h0, p_rise};
                    REG_FALL:    rd = {16'h0, p_fall};
                    REG_MASK:    rd = {16'h0, p_mask};
                    REG_PENDING: rd = {16'h0, p_pend};
                    default:     rd = '0;
                endcase
            end
            KIND_WRITE:
            begin
                case (idx)
                    REG_MODE:     p_mode = d;
                    REG_OTYPE:    p_otype = d[15:0];
                    REG_SPEED:    p_speed = d;
                    REG_PULL:     p_pull = d;
                    REG_ODR:      p_odr = d[15:0];
                    // set wins over reset on the same pin
                    REG_SETRESET: p_odr = (p_odr & ~d[31:16]) | d[15:0];
                    REG_AFLOW:    p_aflow = d;
                    REG_AFHIGH:   p_afhigh = d;
                    REG_RISE:     p_rise = d[15:0];
                    REG_FALL:     p_fall = d[15:0];
                    REG_MASK:     p_mask = d[15:0];
                    REG_PENDING:  p_pend = p_pend & ~d[15:0];
                    REG_SWTRIG:   p_pend = p_pend | d[15:0];
                    default:      ;
                endcase
            end
            KIND_TICK:
            begin
                // analog pins latch low
                now = lv & ~mode_match(p_mode, MODE_ANALOG);
                p_pend = p_pend | (now & ~p_idr & p_rise) | (~now & p_idr & p_fall);
                p_idr = now;
            end
            default: ;
        endcase
        act = p_pend & p_mask;
        r.read_data  = rd;
        r.out_levels = p_odr;
        r.out_enable = mode_match(p_mode, MODE_OUTPUT);
        r.open_drain = p_otype;
        r.irq_lines  = {|act[15:10], |act[9:5], act[4:0]};
    endtask

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        if (err_count < PRINT_LIMIT)
            $display("mismatch %s at cycle %0d: got %h want %h", what, cycles, got, want);
        err_count++;
    endtask

    // receiver side: after each item taken, hold out_ready low for a randomly picked wait
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (out_valid && out_ready)
        begin
            rx_wait = pick_wait();
            out_ready <= (rx_wait == 0);
        end
        else if (!out_ready)
        begin
            if (rx_wait > 0)
                rx_wait--;
            out_ready <= (rx_wait == 0);
        end
    end

    // checks replies in order and books the expectation of every item taken
    always @(posedge clk)
    begin
        result_t want;
        result_t pred;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (replies.size() == 0)
                    report("reply with nothing expected", read_data, '0);
                else
                begin
                    want = replies.pop_front();
                    if (read_data !== want.read_data)
                        report("read_data", read_data, want.read_data);
                    if (out_levels !== want.out_levels)
                        report("out_levels", {16'h0, out_levels}, {16'h0, want.out_levels});
                    if (out_enable !== want.out_enable)
                        report("out_enable", {16'h0, out_enable}, {16'h0, want.out_enable});
                    if (open_drain !== want.open_drain)
                        report("open_drain", {16'h0, open_drain}, {16'h0, want.open_drain});
                    if (irq_lines !== want.irq_lines)
                        report("irq_lines", {25'h0, irq_lines}, {25'h0, want.irq_lines});
                end
            end
            if (in_valid && in_ready)
            begin
                port_next(kind_t'(kind), reg_index_t'(reg_index), write_data, pin_levels, pred);
                replies.push_back(row_fixed ? row_want : pred);
            end
        end
    end

    task automatic add_row(input kind_t k, input reg_index_t idx, input logic [31:0] d,
                           input logic [15:0] lv, input bit fixed, input result_t want);
        bus_row_t row;
        row.k = k;
        row.idx = idx;
        row.d = d;
        row.lv = lv;
        row.fixed = fixed;
        row.want = want;
        script.push_back(row);
    endtask

    // returns at the edge where the item was taken
    task automatic send_item(input bus_row_t row);
        int gap;
        gap = pick_wait();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        kind       <= row.k;
        reg_index  <= row.idx;
        write_data <= row.d;
        pin_levels <= row.lv;
        row_fixed  <= row.fixed;
        row_want   <= row.want;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic make_random(inout logic [15:0] pins, output bus_row_t row);
        int pick;
        pick = $urandom_range(0, 99);
        row.d = $urandom;
        row.lv = 16'($urandom);
        row.fixed = 1'b0;
        row.want = '0;
        row.idx = reg_index_t'($urandom_range(0, 15));
        if (pick < 2)
            row.k = KIND_NONE;
        else if (pick < 42)
        begin
            row.k = KIND_TICK;
            // mostly a few pins toggling, sometimes a fresh random pattern
            if ($urandom_range(0, 3) != 0)
                pins = pins ^ 16'($urandom & $urandom);
            else
                pins = 16'($urandom);
            row.lv = pins;
        end
        else if (pick < 62)
            row.k = KIND_READ;
        else
        begin
            row.k = KIND_WRITE;
            if (row.idx == REG_MODE && $urandom_range(0, 1) == 1)
                row.d = row.d & 32'h5555_5555;
        end
    endtask

    initial
    begin
        bus_row_t    row;
        logic [15:0] pins;
        pins = '0;

        add_row(KIND_READ,  REG_MODE,     32'h0000_0000, 16'hFFFF, 1'b1, idle_reply(16'h0000));
        add_row(KIND_READ,  REG_PENDING,  32'hFFFF_FFFF, 16'h0000, 1'b1, idle_reply(16'h0000));
        add_row(KIND_WRITE, REG_ODR,      32'hFFFF_FFFF, 16'h0000, 1'b1, idle_reply(16'hFFFF));
        add_row(KIND_WRITE, REG_SETRESET, 32'hFFFF_0000, 16'h0000, 1'b1, idle_reply(16'h0000));
        add_row(KIND_WRITE, REG_SETRESET, 32'hFFFF_FFFF, 16'h0000, 1'b1, idle_reply(16'hFFFF));
        add_row(KIND_WRITE, REG_SETRESET, 32'h0001_0002, 16'h0000, 1'b0, '0);
        add_row(KIND_WRITE, REG_OTYPE,    32'hFFFF_FFFF, 16'h0000, 1'b0, '0);
        // idr is read-only
        add_row(KIND_WRITE, REG_IDR,      32'hFFFF_FFFF, 16'h0000, 1'b0, '0);
        add_row(KIND_READ,  REG_IDR,      32'h0000_0000, 16'h0000, 1'b0, '0);
        add_row(KIND_WRITE, REG_MODE,     32'h5555_5555, 16'h0000, 1'b0, '0);
        add_row(KIND_WRITE, REG_RISE,     32'hFFFF_FFFF, 16'h0000, 1'b0, '0);
        add_row(KIND_WRITE, REG_FALL,     32'hFFFF_FFFF, 16'h0000, 1'b0, '0);
        add_row(KIND_WRITE, REG_MASK,     32'hFFFF_FFFF, 16'h0000, 1'b0, '0);
        add_row(KIND_TICK,  REG_MODE,     32'h0000_0000, 16'hFFFF, 1'b0, '0);
        add_row(KIND_WRITE, REG_PENDING,  32'h0000_FFFF, 16'h0000, 1'b0, '0);
        // all pins analog: latch drops to zero, falling edges everywhere
        add_row(KIND_WRITE, REG_MODE,     32'hFFFF_FFFF, 16'h0000, 1'b0, '0);
        add_row(KIND_TICK,  REG_MODE,     32'h0000_0000, 16'hFFFF, 1'b0, '0);
        add_row(KIND_READ,  REG_PENDING,  32'h0000_0000, 16'h0000, 1'b0, '0);
        add_row(KIND_WRITE, REG_PENDING,  32'h0000_7FFE, 16'h0000, 1'b0, '0);
        add_row(KIND_WRITE, REG_SWTRIG,   32'h0000_0420, 16'h0000, 1'b0, '0);
        add_row(KIND_READ,  REG_SWTRIG,   32'h0000_0000, 16'h0000, 1'b0, '0);
        add_row(KIND_WRITE, REG_AFHIGH,   32'hA5A5_A5A5, 16'h0000, 1'b0, '0);
        add_row(KIND_READ,  REG_AFHIGH,   32'h0000_0000, 16'h0000, 1'b0, '0);
        add_row(KIND_READ,  REG_UNUSED14, 32'h0000_0000, 16'h0000, 1'b0, '0);
        add_row(KIND_WRITE, REG_UNUSED15, 32'hFFFF_FFFF, 16'h0000, 1'b0, '0);
        add_row(KIND_NONE,  REG_MODE,     32'hFFFF_FFFF, 16'hFFFF, 1'b0, '0);
        add_row(KIND_READ,  REG_MODE,     32'h0000_0000, 16'h0000, 1'b0, '0);

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (script[i])
            send_item(script[i]);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            // every fifth stretch runs with no idling on either side
            calm = ((n / 50) % 5) == 4;
            make_random(pins, row);
            send_item(row);
        end
        calm = 1'b0;

        in_valid <= 1'b0;
        while (replies.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (err_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[sim.f]
hdl/gpe_pkg.sv
hdl/gpe_regs.sv
hdl/gpio_port_edge_interrupt_core.sv
sim/testbench.sv
